// ===== hdl/vc_pkg.sv =====
// Shared constants and types for the valid-mode 2D convolution core.
package vc_pkg;

	localparam int MAX_KERNEL_D = 5;
	localparam int MAX_COLS_D   = 1024;
	localparam int DATA_BITS_D  = 16;

	localparam int SUM_W      = 36;   // result width, sums wrap here
	localparam int ROW_W      = 10;   // row counter width
	localparam int OUT_POS_W  = 10;   // result row and column width
	localparam int ROW_LIMIT  = 1024;
	localparam int IDX_W      = 5;    // coefficient index field
	localparam int GEOM_W     = 11;   // image geometry registers
	localparam int KDIM_W     = 3;    // kernel geometry registers
	localparam int CFG_ADDR_W = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_IMAGE_ROWS  = 2'd0,
		CFG_IMAGE_COLS  = 2'd1,
		CFG_KERNEL_ROWS = 2'd2,
		CFG_KERNEL_COLS = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] row;
		logic [OUT_POS_W-1:0] col;
		logic                 last;
	} meta_t;

endpackage

// ===== hdl/vc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/vc_cell.sv =====
// One window column cell: holds a column, passes it on, multiplies and sums it.
module vc_cell import vc_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_D,
	parameter int DATA_BITS  = DATA_BITS_D
) (
	input  logic                                 clk,
	input  logic                                 shift_en,
	input  logic                                 pipe_en,
	input  logic [MAX_KERNEL-1:0][DATA_BITS-1:0] col_in,
	input  logic [MAX_KERNEL-1:0][DATA_BITS-1:0] coef,
	output logic [MAX_KERNEL-1:0][DATA_BITS-1:0] col_out,
	output logic signed [SUM_W-1:0]              colsum
);

	localparam int PW = 2 * DATA_BITS;

	logic [MAX_KERNEL-1:0][DATA_BITS-1:0] col_q;
	logic signed [PW-1:0]                 prod_s3 [MAX_KERNEL];
	logic signed [SUM_W-1:0]              colsum_s4;
	logic signed [SUM_W-1:0]              acc;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	// products of the column against this cell's coefficients
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < MAX_KERNEL; i++) begin
				prod_s3[i] <= $signed(col_q[i]) * $signed(coef[i]);
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < MAX_KERNEL; i++) begin
			acc = acc + SUM_W'(prod_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			colsum_s4 <= acc;
		end
	end

	assign col_out = col_q;
	assign colsum  = colsum_s4;

endmodule

// ===== hdl/valid_2d_convolution_core.sv =====
// Valid-mode 2D cross-correlation core: line RAMs, column cell chain, adder.
// A window-completing pixel passes stage 1, stages 2 to 4 and the output register.
// One item per cycle unless stalled: the line RAM read and cell chain take a column each cycle.
// A result held on the master side stalls the whole pipeline, input included.
// Reset (arst_n low) clears counters, coefficients, valid bits and geometry to
// 32x32 image, 3x3 kernel; line RAM contents are undefined until written.
module valid_2d_convolution_core import vc_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_D,
	parameter int MAX_COLS   = MAX_COLS_D,
	parameter int DATA_BITS  = DATA_BITS_D,
	localparam int IN_TW  = ((IDX_W + 2 * DATA_BITS + 7) / 8) * 8,
	localparam int OUT_TW = ((SUM_W + 2 * OUT_POS_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TW-1:0]      s_tdata,   // coef_index, coef_value, pixel (low to high)
	input  logic                  s_tuser,   // action: 0 load coefficient, 1 pixel
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_TW-1:0]     m_tdata,   // out_value, out_row, out_col (low to high)
	output logic                  m_tlast,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [GEOM_W-1:0]     cfg_wdata
);

	localparam int KSQ = MAX_KERNEL * MAX_KERNEL;
	localparam int CW  = $clog2(MAX_COLS);
	localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int SLW = $clog2(3 * MAX_KERNEL);
	localparam int KW  = $clog2(MAX_KERNEL + 1);
	localparam int EW  = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;
	localparam int CIW = (KSQ > 1) ? $clog2(KSQ) : 1;

	// geometry registers
	logic [GEOM_W-1:0] img_rows_q, img_cols_q;
	logic [KDIM_W-1:0] k_rows_q, k_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_rows_q <= GEOM_W'(32);
			img_cols_q <= GEOM_W'(32);
			k_rows_q   <= KDIM_W'(3);
			k_cols_q   <= KDIM_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_IMAGE_ROWS:  img_rows_q <= cfg_wdata;
				CFG_IMAGE_COLS:  img_cols_q <= cfg_wdata;
				CFG_KERNEL_ROWS: k_rows_q   <= cfg_wdata[KDIM_W-1:0];
				CFG_KERNEL_COLS: k_cols_q   <= cfg_wdata[KDIM_W-1:0];
			endcase
		end
	end

	// clamped geometry
	logic [GEOM_W-1:0] rows_eff;
	logic [EW-1:0]     cols_eff;
	logic [KW-1:0]     kr_eff, kc_eff;

	always_comb begin
		if (img_rows_q == '0) begin
			rows_eff = GEOM_W'(1);
		end else if (img_rows_q > GEOM_W'(ROW_LIMIT)) begin
			rows_eff = GEOM_W'(ROW_LIMIT);
		end else begin
			rows_eff = img_rows_q;
		end
		if (img_cols_q == '0) begin
			cols_eff = EW'(1);
		end else if (EW'(img_cols_q) > EW'(MAX_COLS)) begin
			cols_eff = EW'(MAX_COLS);
		end else begin
			cols_eff = EW'(img_cols_q);
		end
		if (k_rows_q == '0) begin
			kr_eff = KW'(1);
		end else if (int'(k_rows_q) > MAX_KERNEL) begin
			kr_eff = KW'(MAX_KERNEL);
		end else begin
			kr_eff = KW'(k_rows_q);
		end
		if (k_cols_q == '0) begin
			kc_eff = KW'(1);
		end else if (int'(k_cols_q) > MAX_KERNEL) begin
			kc_eff = KW'(MAX_KERNEL);
		end else begin
			kc_eff = KW'(k_cols_q);
		end
	end

	// handshake: whole pipeline advances unless the output register is stuck
	logic out_vld_q;
	logic en, acc_in, is_pix;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign acc_in   = s_tvalid && s_tready;
	assign is_pix   = (action_t'(s_tuser) == ACT_PIXEL);

	logic [IDX_W-1:0]     in_cidx;
	logic [DATA_BITS-1:0] in_cval, in_pixel;

	assign in_cidx  = s_tdata[IDX_W-1:0];
	assign in_cval  = s_tdata[IDX_W +: DATA_BITS];
	assign in_pixel = s_tdata[IDX_W + DATA_BITS +: DATA_BITS];

	// position of the incoming pixel
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic [SW-1:0]    slot_q;
	logic [ROW_W-1:0] r_cur;
	logic [CW-1:0]    c_cur;
	logic [SW-1:0]    slot_cur;
	logic             in_range;

	assign in_range = (GEOM_W'(row_q) < rows_eff) && (EW'(col_q) < cols_eff);
	assign r_cur    = in_range ? row_q : '0;
	assign c_cur    = in_range ? col_q : '0;
	assign slot_cur = in_range ? slot_q : '0;

	logic [ROW_W:0] r_p1;
	logic [CW:0]    c_p1;
	logic           emit_d, last_d, row_end, img_end;
	meta_t          meta_d;

	assign r_p1    = {1'b0, r_cur} + 1'b1;
	assign c_p1    = {1'b0, c_cur} + 1'b1;
	assign emit_d  = (r_p1 >= (ROW_W + 1)'(kr_eff)) && (c_p1 >= (CW + 1)'(kc_eff));
	assign row_end = (EW'(c_p1) >= cols_eff);
	assign img_end = (GEOM_W'(r_p1) >= rows_eff);
	assign last_d  = (GEOM_W'(r_p1) == rows_eff) && (EW'(c_p1) == cols_eff);

	always_comb begin
		meta_d.row  = OUT_POS_W'(r_p1 - (ROW_W + 1)'(kr_eff));
		meta_d.col  = OUT_POS_W'(c_p1 - (CW + 1)'(kc_eff));
		meta_d.last = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (cfg_we) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (acc_in && is_pix) begin
			if (row_end) begin
				col_q <= '0;
				if (img_end) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= r_p1[ROW_W-1:0];
					slot_q <= (int'(slot_cur) == MAX_KERNEL - 1) ? '0 : slot_cur + 1'b1;
				end
			end else begin
				col_q <= c_p1[CW-1:0];
			end
		end
	end

	// line RAM slot of each window row: (slot + 1 - kr + i) mod MAX_KERNEL
	logic [MAX_KERNEL-1:0][SW-1:0] sel_d;
	logic [SLW-1:0]                t;

	always_comb begin
		t = '0;
		for (int i = 0; i < MAX_KERNEL; i++) begin
			t = SLW'(slot_cur) + SLW'(MAX_KERNEL + 1 + i) - SLW'(kr_eff);
			if (t >= SLW'(2 * MAX_KERNEL)) begin
				t = t - SLW'(2 * MAX_KERNEL);
			end else if (t >= SLW'(MAX_KERNEL)) begin
				t = t - SLW'(MAX_KERNEL);
			end
			sel_d[i] = SW'(t);
		end
	end

	// line RAMs, one per kernel row slot
	logic [DATA_BITS-1:0] rdata [MAX_KERNEL];

	for (genvar s = 0; s < MAX_KERNEL; s++) begin : g_line
		vc_ram #(
			.WIDTH(DATA_BITS),
			.DEPTH(MAX_COLS)
		) u_line (
			.clk  (clk),
			.we   (acc_in && is_pix && (int'(slot_cur) == s)),
			.waddr(c_cur),
			.wdata(in_pixel),
			.re   (acc_in),
			.raddr(c_cur),
			.rdata(rdata[s])
		);
	end

	// stage 1: RAM read done
	logic                          vld_s1, pix_s1, emit_s1;
	logic [DATA_BITS-1:0]          pixel_s1, cval_s1;
	logic [IDX_W-1:0]              cidx_s1;
	logic [MAX_KERNEL-1:0][SW-1:0] sel_s1;
	meta_t                         meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			pix_s1   <= is_pix;
			emit_s1  <= emit_d;
			pixel_s1 <= in_pixel;
			cval_s1  <= in_cval;
			cidx_s1  <= in_cidx;
			sel_s1   <= sel_d;
			meta_s1  <= meta_d;
		end
	end

	// new window column, top row first; the newest row is the pixel itself,
	// rows below the kernel height carry zero
	logic [MAX_KERNEL-1:0][DATA_BITS-1:0] col_new;

	always_comb begin
		for (int i = 0; i < MAX_KERNEL; i++) begin
			if (i > int'(kr_eff) - 1) begin
				col_new[i] = '0;
			end else if (i == int'(kr_eff) - 1) begin
				col_new[i] = pixel_s1;
			end else begin
				col_new[i] = rdata[sel_s1[i]];
			end
		end
	end

	// coefficients are written in item order, at the same edge as window shifts
	logic [DATA_BITS-1:0] coef_q [KSQ];
	logic                 coef_wr;

	assign coef_wr = en && vld_s1 && !pix_s1 && (int'(cidx_s1) < KSQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KSQ; k++) begin
				coef_q[k] <= '0;
			end
		end else if (coef_wr) begin
			coef_q[CIW'(cidx_s1)] <= cval_s1;
		end
	end

	// stage 2..4 valid and result position
	logic  vld_s2, vld_s3, vld_s4;
	meta_t meta_s2, meta_s3, meta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1 && pix_s1 && emit_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
		end
	end

	// cell chain: cell a holds the column a pixels old, i.e. window column kc-1-a
	logic [MAX_KERNEL-1:0][DATA_BITS-1:0] chain    [MAX_KERNEL + 1];
	logic [MAX_KERNEL-1:0][DATA_BITS-1:0] cell_coef[MAX_KERNEL];
	logic signed [SUM_W-1:0]              colsum   [MAX_KERNEL];
	logic                                 shift_en;

	assign shift_en = en && vld_s1 && pix_s1;
	assign chain[0] = col_new;

	always_comb begin
		for (int a = 0; a < MAX_KERNEL; a++) begin
			for (int i = 0; i < MAX_KERNEL; i++) begin
				if ((i < int'(kr_eff)) && (a < int'(kc_eff))) begin
					cell_coef[a][i] =
						coef_q[CIW'(i * int'(kc_eff) + int'(kc_eff) - 1 - a)];
				end else begin
					cell_coef[a][i] = '0;
				end
			end
		end
	end

	for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_cell
		vc_cell #(
			.MAX_KERNEL(MAX_KERNEL),
			.DATA_BITS (DATA_BITS)
		) u_cell (
			.clk     (clk),
			.shift_en(shift_en),
			.pipe_en (en),
			.col_in  (chain[a]),
			.coef    (cell_coef[a]),
			.col_out (chain[a + 1]),
			.colsum  (colsum[a])
		);
	end

	// final sum across the cells inside the kernel width into the output register
	logic signed [SUM_W-1:0] total;
	logic [SUM_W-1:0]        value_q;
	meta_t                   meta_q;

	always_comb begin
		total = '0;
		for (int a = 0; a < MAX_KERNEL; a++) begin
			if (a < int'(kc_eff)) begin
				total = total + colsum[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s4) begin
			value_q <= total;
			meta_q  <= meta_s4;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TW'({meta_q.col, meta_q.row, value_q});
	assign m_tlast  = meta_q.last;

endmodule

// ===== hdl/vc_checker.sv =====
// Port-level checks for the convolution core, bound to the top level.
module vc_port_props #(
	parameter int OUT_TW = 56
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata,
	input logic              m_tlast
);

	logic acc_in;

	assign acc_in = s_tvalid && s_tready;

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// with no input transfer and no result over the checked history, the pipeline stays drained
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !acc_in
			&& !$past(m_tvalid, 1) && !$past(acc_in, 1)
			&& !$past(m_tvalid, 2) && !$past(acc_in, 2)
			&& !$past(m_tvalid, 3) && !$past(acc_in, 3)
			&& !$past(m_tvalid, 4) && !$past(acc_in, 4)) |=> !m_tvalid)
		else $error("result without a recent input transfer");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
		else $error("result changed while stalled");

endmodule

bind valid_2d_convolution_core vc_port_props #(.OUT_TW(OUT_TW)) u_vc_port_props (.*);

// ===== tb/vc_checker.sv =====
// Scoreboard for the convolution core: mirrors its state, predicts results, compares.
module vc_checker import vc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [39:0]           s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [55:0]           m_tdata,
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [GEOM_W-1:0]     cfg_wdata,
	output int                    pending,
	output int                    fails
);

	typedef struct packed {
		logic [SUM_W-1:0]     value;
		logic [OUT_POS_W-1:0] row;
		logic [OUT_POS_W-1:0] col;
		logic                 last;
	} conv_result_t;

	conv_result_t results_due[$];
	logic signed [15:0] line_buf [5][1024];
	logic signed [15:0] coef [25];
	int unsigned geo_rows, geo_cols, ker_rows, ker_cols;
	int unsigned next_row, next_col;

	function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("vc_checker: %s mismatch: got %0h, expected %0h", what, got, want);
		fails++;
	endtask

	// one pixel: store it, sum the window it completes, advance the raster position
	task automatic convolve_pixel(logic signed [15:0] px);
		int unsigned nr, nc, kr, kc, r, c, slot;
		longint acc;
		conv_result_t res;
		nr = clampv(geo_rows, 1, ROW_LIMIT);
		nc = clampv(geo_cols, 1, 1024);
		kr = clampv(ker_rows, 1, 5);
		kc = clampv(ker_cols, 1, 5);
		r = next_row;
		c = next_col;
		if (r >= nr || c >= nc) begin
			r = 0;
			c = 0;
		end
		line_buf[r % 5][c] = px;
		if (r + 1 >= kr && c + 1 >= kc) begin
			acc = 0;
			for (int i = 0; i < kr; i++) begin
				slot = (r + 1 - kr + i) % 5;
				for (int j = 0; j < kc; j++)
					acc += longint'(line_buf[slot][c + 1 - kc + j]) * longint'(coef[i * kc + j]);
			end
			res.value = acc[SUM_W-1:0];
			res.row   = OUT_POS_W'(r + 1 - kr);
			res.col   = OUT_POS_W'(c + 1 - kc);
			res.last  = (r + 1 == nr && c + 1 == nc);
			results_due.push_back(res);
		end
		c++;
		if (c >= nc) begin
			c = 0;
			r++;
			if (r >= nr)
				r = 0;
		end
		next_row = r;
		next_col = c;
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_result_t want;
		if (!arst_n) begin
			results_due.delete();
			foreach (coef[k]) coef[k] = '0;
			geo_rows = 32;
			geo_cols = 32;
			ker_rows = 3;
			ker_cols = 3;
			next_row = 0;
			next_col = 0;
			fails    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report("unexpected result", m_tdata, 0);
				end else begin
					want = results_due.pop_front();
					if (m_tdata[35:0] !== want.value) report("value", m_tdata[35:0], want.value);
					if (m_tdata[45:36] !== want.row) report("row", m_tdata[45:36], want.row);
					if (m_tdata[55:46] !== want.col) report("col", m_tdata[55:46], want.col);
					if (m_tlast !== want.last) report("last", m_tlast, want.last);
				end
			end
			// any geometry write restarts the frame
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					CFG_IMAGE_ROWS:  geo_rows = int'(cfg_wdata);
					CFG_IMAGE_COLS:  geo_cols = int'(cfg_wdata);
					CFG_KERNEL_ROWS: ker_rows = int'(cfg_wdata[KDIM_W-1:0]);
					CFG_KERNEL_COLS: ker_cols = int'(cfg_wdata[KDIM_W-1:0]);
				endcase
				next_row = 0;
				next_col = 0;
			end
			if (s_tvalid && s_tready) begin
				if (action_t'(s_tuser) == ACT_LOAD) begin
					if (s_tdata[4:0] < 25)
						coef[s_tdata[4:0]] = s_tdata[20:5];
				end else begin
					convolve_pixel(s_tdata[36:21]);
				end
			end
		end
		pending = results_due.size();
	end

endmodule

// ===== tb/valid_2d_convolution_core_tb.sv =====
// Testbench top: drives stimulus and configuration for the convolution core, gives the verdict.
module valid_2d_convolution_core_tb;
	import vc_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [39:0]           s_tdata;   // coef_index, coef_value, pixel (low to high)
	logic                  s_tuser;   // action
	logic                  m_tvalid;
	logic                  m_tready;
	logic [55:0]           m_tdata;   // out_value, out_row, out_col (low to high)
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [GEOM_W-1:0]     cfg_wdata;
	int                    pending;
	int                    fails;

	// sender burst shaping
	int burst_left;
	bit gaps_on;
	// receiver shaping: stall percentage and a one-shot long hold-off request
	int stall_pct;
	bit hold_req;
	int hold_cnt;
	int pixels_sent;

	valid_2d_convolution_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	vc_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.fails     (fails)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request so the core backs up
	initial begin
		m_tready = 1'b0;
		hold_cnt = 0;
		forever @(posedge clk) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		#400000;
		$display("valid_2d_convolution_core_tb: FAIL");
		$finish;
	end

	// one transfer on the slave side; gaps fall between bursts
	task automatic send(action_t act, logic [4:0] idx, logic [15:0] cval, logic [15:0] px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, px, cval, idx};
		do @(posedge clk); while (!s_tready);
		if (act == ACT_PIXEL) pixels_sent++;
	endtask

	task automatic load_coef(logic [4:0] idx, logic [15:0] cval);
		send(ACT_LOAD, idx, cval, 16'($urandom));
	endtask

	task automatic pixel(logic [15:0] px);
		send(ACT_PIXEL, 5'($urandom), 16'($urandom), px);
	endtask

	// stop offering, let every expected result arrive, then cover the pipeline latency
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// only called while idle; writes all four geometry registers back to back
	task automatic set_geometry(int rows, int cols, int kr, int kc);
		int vals [4];
		vals = '{rows, cols, kr, kc};
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= cfg_reg_t'(k);
			cfg_wdata <= GEOM_W'(vals[k]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_all_coefs();
		for (int k = 0; k < 25; k++)
			load_coef(5'(k), 16'($urandom));
	endtask

	initial begin
		int rows, cols, kr, kc, frames, n;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		cfg_we     = 1'b0;
		cfg_addr   = CFG_IMAGE_ROWS;
		cfg_wdata  = '0;
		burst_left = 0;
		gaps_on    = 1'b1;
		stall_pct  = 20;
		hold_req   = 1'b0;
		pixels_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 3x4 image, 2x2 kernel, extreme coefficients and pixels
		set_geometry(3, 4, 2, 2);
		load_coef(5'd0, 16'h7FFF);
		load_coef(5'd1, 16'h8000);
		load_coef(5'd2, 16'hFFFF);
		load_coef(5'd3, 16'h0001);
		load_coef(5'd25, 16'h1234);   // index past the store: ignored
		load_coef(5'd31, 16'hFFFF);
		pixel(16'h8000); pixel(16'h7FFF); pixel(16'hFFFF); pixel(16'h0000);
		pixel(16'h8000); pixel(16'h8000); pixel(16'h7FFF);
		load_coef(5'd0, 16'h8000);    // mid-image load, later windows only
		pixel(16'h0001);
		pixel(16'h7FFF); pixel(16'h8000); pixel(16'h8000); pixel(16'h7FFF);
		drain();

		// kernel taller and wider than the image: no results at all
		set_geometry(2, 2, 3, 3);
		repeat (4) pixel(16'($urandom));
		drain();

		// out-of-range geometry saturates: 1024 rows, 1 column, 5x1 kernel
		set_geometry(2047, 0, 5, 0);
		load_all_coefs();
		repeat (10) pixel(16'($urandom));
		drain();

		// smallest case: 1x1 image, kernel registers zero clamp up to 1x1
		set_geometry(0, 1, 0, 0);
		pixel(16'($urandom));
		pixel(16'($urandom));
		drain();

		// widest row with a clamped 1x5 kernel; long receiver hold-off fills the core
		set_geometry(1, 1024, 1, 7);
		load_all_coefs();
		gaps_on = 1'b0;
		for (int p = 0; p < 1024; p++) begin
			if (p == 40) hold_req = 1'b1;
			pixel(16'($urandom));
		end
		gaps_on = 1'b1;
		drain();

		// random phases: mostly whole frames, sometimes a frame cut short
		while (pixels_sent < 1100) begin
			rows = $urandom_range(1, 8);
			cols = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
			kr   = $urandom_range(0, 7);
			kc   = $urandom_range(0, 7);
			gaps_on   = $urandom_range(0, 2) != 0;
			stall_pct = $urandom_range(0, 2) * 30;
			set_geometry(rows, cols, kr, kc);
			if ($urandom_range(0, 1)) load_all_coefs();
			frames = $urandom_range(1, 3);
			n = frames * rows * cols;
			if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
			if (n > 96) n = 96;
			for (int p = 0; p < n; p++) begin
				// occasional late load, any index including ignored ones
				if ($urandom_range(0, 9) == 0) load_coef(5'($urandom), 16'($urandom));
				pixel(16'($urandom));
			end
			drain();
		end

		if (fails == 0) begin
			$display("valid_2d_convolution_core_tb: PASS");
		end else begin
			$display("valid_2d_convolution_core_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== valid_2d_convolution_core.f =====
hdl/vc_pkg.sv
hdl/vc_ram.sv
hdl/vc_cell.sv
hdl/valid_2d_convolution_core.sv
hdl/vc_checker.sv
tb/vc_checker.sv
tb/valid_2d_convolution_core_tb.sv
